// ----- rtl/core/tbpd_pkg.sv -----
// ----------------------------------------------------------------------------
// tbpd_pkg
// Shared types, constants and helpers for the popcount dot product core.
// ----------------------------------------------------------------------------
package tbpd_pkg;

    // Field widths fixed by the interface
    localparam int PLANE_W  = 64;
    localparam int CNT_W    = 17;
    localparam int RESULT_W = 21;
    localparam int MODE_W   = 3;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;

    // Default build values
    localparam int MAX_WORDS_DEF = 1024;
    localparam int WORD_BITS_DEF = 64;

    // Lane slice width and per-lane popcount width
    localparam int LANE_BITS  = 8;
    localparam int LANE_CNT_W = $clog2(LANE_BITS + 1);

    localparam logic [CNT_W-1:0]    CNT_MAX = '1;
    localparam logic [PLANE_W-1:0]  RTN_EVEN_MASK = 64'h5555_5555_5555_5555;
    localparam logic signed [RESULT_W:0] RES_MAX = 22'sd1048575;
    localparam logic signed [RESULT_W:0] RES_MIN = -22'sd1048576;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BINARY_LENGTH = 1'b1;

    // Operating modes
    typedef enum logic [MODE_W-1:0] {
        MODE_TNN    = 3'd0,
        MODE_TBN    = 3'd1,
        MODE_BTN    = 3'd2,
        MODE_BNN    = 3'd3,
        MODE_TWOBIT = 3'd4,
        MODE_RTN    = 3'd5
    } t_mode;

    // Popcounts one lane found for one word
    typedef struct packed {
        logic [LANE_CNT_W-1:0] c1;
        logic [LANE_CNT_W-1:0] c2;
        logic [LANE_CNT_W-1:0] c3;
        logic [LANE_CNT_W-1:0] c4;
    } t_lane_cnt;

    // Finished run handed from the merge stage to the result stage
    typedef struct packed {
        logic [CNT_W-1:0] c1;
        logic [CNT_W-1:0] c2;
        logic [CNT_W-1:0] c3;
        logic [CNT_W-1:0] c4;
        logic [CNT_W-1:0] wnz;
        logic             ovf;
    } t_fin;

    // Count set bits of one lane slice
    function automatic logic [LANE_CNT_W-1:0] f_pop(input logic [LANE_BITS-1:0] v);
        logic [LANE_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < LANE_BITS; i++) begin
            n = n + LANE_CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// ----- rtl/core/tbpd_lane.sv -----
// ----------------------------------------------------------------------------
// tbpd_lane
// One lane: combines a slice of the bit planes by mode and registers the
// four popcounts of that slice.
// ----------------------------------------------------------------------------
module tbpd_lane
    import tbpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [LANE_BITS-1:0] i_a0,
    input  logic [LANE_BITS-1:0] i_a1,
    input  logic [LANE_BITS-1:0] i_b0,
    input  logic [LANE_BITS-1:0] i_b1,
    input  logic [LANE_BITS-1:0] i_even,
    output t_lane_cnt            o_cnt
);

    logic [LANE_BITS-1:0] x;
    logic [LANE_BITS-1:0] x_rtn;
    logic [LANE_BITS-1:0] nz_rtn;
    logic [LANE_BITS-1:0] v1, v2, v3, v4;
    t_lane_cnt            r_cnt;
    t_lane_cnt            n_cnt;

    // Sign difference, and its one-bit shift for the interleaved form
    assign x      = i_a0 ^ i_b0;
    assign x_rtn  = {1'b0, x[LANE_BITS-1:1]};
    assign nz_rtn = i_a0 & i_b0 & i_even;

    // Select the four operand vectors by mode
    always_comb begin
        v1 = '0;
        v2 = '0;
        v3 = '0;
        v4 = '0;
        unique case (i_mode)
            MODE_TNN: begin
                v1 = i_a1 & i_b1;
                v2 = x & i_a1 & i_b1;
            end
            MODE_TBN: begin
                v1 = i_a1;
                v2 = x & i_a1;
            end
            MODE_BTN: begin
                v2 = x & i_b1;
            end
            MODE_BNN: begin
                v1 = x;
            end
            MODE_TWOBIT: begin
                v1 = i_a0 & i_b0;
                v2 = i_a1 & i_b0;
                v3 = i_a0 & i_b1;
                v4 = i_a1 & i_b1;
            end
            MODE_RTN: begin
                v1 = nz_rtn;
                v2 = x_rtn & nz_rtn;
            end
            default: begin
                v1 = '0;
            end
        endcase
    end

    assign n_cnt = '{c1: f_pop(v1), c2: f_pop(v2), c3: f_pop(v3), c4: f_pop(v4)};

    // Hold lane counts for the merge stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

// ----- rtl/core/tbpd_merge.sv -----
// ----------------------------------------------------------------------------
// tbpd_merge
// Merge stage: sums the lane counts, accumulates them into the saturating
// run counters, tracks run length and hands a finished run onward.
// ----------------------------------------------------------------------------
module tbpd_merge
    import tbpd_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF,
    parameter int NUM_LANES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic                         i_last,
    input  logic [CNT_W-1:0]             i_wnz,
    input  t_lane_cnt [NUM_LANES-1:0]    i_lane_cnt,
    input  logic                         i_fin_take,
    output logic                         o_fin_valid,
    output logic                         o_fin_free,
    output t_fin                         o_fin
);

    localparam int SUM_W   = $clog2(NUM_LANES * LANE_BITS + 1);
    localparam int WORDS_W = $clog2(MAX_WORDS + 1);
    localparam logic [WORDS_W-1:0] WordsMax = WORDS_W'(MAX_WORDS);

    logic [SUM_W-1:0]   s1, s2, s3, s4;
    logic [CNT_W-1:0]   r_c1, r_c2, r_c3, r_c4;
    logic [CNT_W-1:0]   n_c1, n_c2, n_c3, n_c4;
    logic [WORDS_W-1:0] r_words, n_words;
    logic               r_ovf, n_ovf;
    logic               r_fin_valid;
    t_fin               r_fin;
    logic               full;

    function automatic logic [CNT_W-1:0] f_sat_add(input logic [CNT_W-1:0] acc,
                                                   input logic [SUM_W-1:0] inc);
        logic [CNT_W:0] s;
        s = {1'b0, acc} + (CNT_W + 1)'(inc);
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // Sum lane counts
    always_comb begin
        s1 = '0;
        s2 = '0;
        s3 = '0;
        s4 = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            s1 = s1 + SUM_W'(i_lane_cnt[i].c1);
            s2 = s2 + SUM_W'(i_lane_cnt[i].c2);
            s3 = s3 + SUM_W'(i_lane_cnt[i].c3);
            s4 = s4 + SUM_W'(i_lane_cnt[i].c4);
        end
    end

    // Accumulate, or drop the word once the run is over length
    assign full = (r_words >= WordsMax);

    always_comb begin
        n_c1    = r_c1;
        n_c2    = r_c2;
        n_c3    = r_c3;
        n_c4    = r_c4;
        n_words = r_words;
        n_ovf   = r_ovf;
        if (full) begin
            n_ovf = 1'b1;
        end else begin
            n_c1    = f_sat_add(r_c1, s1);
            n_c2    = f_sat_add(r_c2, s2);
            n_c3    = f_sat_add(r_c3, s3);
            n_c4    = f_sat_add(r_c4, s4);
            n_words = r_words + WORDS_W'(1);
        end
    end

    // Run state: advance per word, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= '0;
            r_c4    <= '0;
            r_words <= '0;
            r_ovf   <= 1'b0;
        end else if (i_go) begin
            if (i_last) begin
                r_c1    <= '0;
                r_c2    <= '0;
                r_c3    <= '0;
                r_c4    <= '0;
                r_words <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_c1    <= n_c1;
                r_c2    <= n_c2;
                r_c3    <= n_c3;
                r_c4    <= n_c4;
                r_words <= n_words;
                r_ovf   <= n_ovf;
            end
        end
    end

    // Finished-run register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= (i_go && i_last) || (r_fin_valid && !i_fin_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_last) begin
            r_fin <= '{c1: n_c1, c2: n_c2, c3: n_c3, c4: n_c4, wnz: i_wnz, ovf: n_ovf};
        end
    end

    assign o_fin_valid = r_fin_valid;
    assign o_fin_free  = !r_fin_valid || i_fin_take;
    assign o_fin       = r_fin;

    // Run length never passes the limit
    a_words_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_words <= WordsMax)
        else $error("run length above limit");

    // Overlength flag only once the limit is reached
    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_words == WordsMax))
        else $error("overlength flag without full run");

    // A finished run is never overwritten while waiting
    a_fin_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_last) |-> o_fin_free)
        else $error("finished run overwritten");

endmodule

// ----- rtl/core/ternary_binary_popcount_dot_product_core.sv -----
// ----------------------------------------------------------------------------
// ternary_binary_popcount_dot_product_core
// Quantized popcount dot product over runs of packed bit-plane words.
// ----------------------------------------------------------------------------
// The core takes one word transaction per clock unless the input stalls.
// Each word is split across parallel lanes of LANE_BITS bits that popcount
// the mode's AND/XOR plane combinations in one stage; a merge stage adds
// the lane counts into four saturating run counters. The result transaction
// of the word flagged last passes from the lane registers, which load at
// the edge that accepts the word, to the merge stage's finished-run register
// and then to the output register. Input stalls only when a last word waits
// behind a finished result that the output side is holding off. The user
// must write mode and binary_length through the configuration port only
// while idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module ternary_binary_popcount_dot_product_core
    import tbpd_pkg::*;
#(
    parameter int MAX_WORDS = MAX_WORDS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    // Input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [PLANE_W-1:0]         i_act_plane_lo,
    input  logic [PLANE_W-1:0]         i_act_plane_hi,
    input  logic [PLANE_W-1:0]         i_wgt_plane_lo,
    input  logic [PLANE_W-1:0]         i_wgt_plane_hi,
    input  logic [CNT_W-1:0]           i_weight_nonzero_count,
    input  logic                       i_last,
    // Output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [RESULT_W-1:0] o_dot_result,
    output logic                       o_too_long
);

    localparam int NumLanes = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
    localparam logic [PLANE_W-1:0] WordMask =
        (WORD_BITS >= PLANE_W) ? '1 : ((PLANE_W'(1) << WORD_BITS) - PLANE_W'(1));

    logic [MODE_W-1:0]         r_mode;
    logic [CFG_W-1:0]          r_bin_len;
    logic [PLANE_W-1:0]        a0_m, a1_m, b0_m, b1_m;
    logic                      r_s1_valid, r_s1_last;
    logic [CNT_W-1:0]          r_s1_wnz;
    logic                      s1_go, s1_free, in_acc;
    t_lane_cnt [NumLanes-1:0]  lane_cnt;
    logic                      fin_valid, fin_free, out_rdy;
    t_fin                      fin;
    logic signed [RESULT_W:0]  res_wide;
    logic signed [RESULT_W-1:0] res_sat;
    logic                      r_out_valid;
    logic signed [RESULT_W-1:0] r_out_res;
    logic                      r_out_ovf;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= '0;
            r_bin_len <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_MODE:          r_mode    <= i_cfg_wdata[MODE_W-1:0];
                REG_BINARY_LENGTH: r_bin_len <= i_cfg_wdata;
                default:           r_mode    <= r_mode;
            endcase
        end
    end

    // Flow control
    assign out_rdy    = !r_out_valid || !i_out_stall;
    assign s1_go      = r_s1_valid && (!r_s1_last || fin_free);
    assign s1_free    = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    // Drop bits above the word width
    assign a0_m = i_act_plane_lo & WordMask;
    assign a1_m = i_act_plane_hi & WordMask;
    assign b0_m = i_wgt_plane_lo & WordMask;
    assign b1_m = i_wgt_plane_hi & WordMask;

    // Lane stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_acc || (r_s1_valid && !s1_go);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_last <= i_last;
            r_s1_wnz  <= i_weight_nonzero_count;
        end
    end

    // Parallel popcount lanes
    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        tbpd_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (in_acc),
            .i_mode (r_mode),
            .i_a0   (a0_m[g*LANE_BITS +: LANE_BITS]),
            .i_a1   (a1_m[g*LANE_BITS +: LANE_BITS]),
            .i_b0   (b0_m[g*LANE_BITS +: LANE_BITS]),
            .i_b1   (b1_m[g*LANE_BITS +: LANE_BITS]),
            .i_even (RTN_EVEN_MASK[g*LANE_BITS +: LANE_BITS]),
            .o_cnt  (lane_cnt[g])
        );
    end

    // Merge and accumulate
    tbpd_merge #(
        .MAX_WORDS (MAX_WORDS),
        .NUM_LANES (NumLanes)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (s1_go),
        .i_last      (r_s1_last),
        .i_wnz       (r_s1_wnz),
        .i_lane_cnt  (lane_cnt),
        .i_fin_take  (out_rdy),
        .o_fin_valid (fin_valid),
        .o_fin_free  (fin_free),
        .o_fin       (fin)
    );

    // Combine the counters by mode
    always_comb begin
        unique case (r_mode)
            MODE_TNN, MODE_TBN, MODE_RTN: begin
                res_wide = $signed({5'b0, fin.c1}) - $signed({4'b0, fin.c2, 1'b0});
            end
            MODE_BTN: begin
                res_wide = $signed({5'b0, fin.wnz}) - $signed({4'b0, fin.c2, 1'b0});
            end
            MODE_BNN: begin
                res_wide = $signed({5'b0, r_bin_len}) - $signed({4'b0, fin.c1, 1'b0});
            end
            MODE_TWOBIT: begin
                res_wide = $signed({3'b0, fin.c1, 2'b0})
                         + $signed({4'b0, fin.c2, 1'b0})
                         + $signed({4'b0, fin.c3, 1'b0})
                         + $signed({5'b0, fin.c4});
            end
            default: begin
                res_wide = '0;
            end
        endcase
    end

    // Clamp to the result range
    always_comb begin
        if (res_wide > RES_MAX) begin
            res_sat = RES_MAX[RESULT_W-1:0];
        end else if (res_wide < RES_MIN) begin
            res_sat = RES_MIN[RESULT_W-1:0];
        end else begin
            res_sat = res_wide[RESULT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_rdy) begin
            r_out_valid <= fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && fin_valid) begin
            r_out_res <= res_sat;
            r_out_ovf <= fin.ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_dot_result = r_out_res;
    assign o_too_long   = r_out_ovf;

    // Input stalls only behind a last word that cannot move on
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s1_last && fin_valid && i_out_stall))
        else $error("input stalled without a blocked last word");

    // A waiting finished run reaches the output once the output frees up
    a_fin_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_valid && out_rdy) |=> r_out_valid)
        else $error("finished run lost before output");

    // A lane-stage word that cannot move on stays held and is not overwritten
    a_lane_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> r_s1_valid && $stable(r_s1_last))
        else $error("lane stage overwritten");

endmodule

// ----- test/ternary_binary_popcount_dot_product_core_tb.sv -----
// ----------------------------------------------------------------------------
// ternary_binary_popcount_dot_product_core_tb
// Self-checking bench for the popcount dot product core.
// ----------------------------------------------------------------------------
// A queue-fed driver streams word transactions with random gaps, and a
// monitor checks every result transaction against a bit-accurate predictor
// of the run counters. Directed words cover each mode, the unused modes,
// plane extremes, a mode change inside a run and a run one word past the
// word limit. Random phases then change mode and binary_length between runs
// and vary both sides' idle cycles, including one long output hold-off that
// backs up the input.
// ----------------------------------------------------------------------------
module ternary_binary_popcount_dot_product_core_tb;
    import tbpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PIPE_DRAIN   = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 700;
    localparam int RUN_LIMIT    = MAX_WORDS_DEF;
    localparam logic [CNT_W-1:0] WNZ_MID = 17'd65536;

    // Modes with no operation assigned
    localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

    typedef struct {
        logic [PLANE_W-1:0] act_lo;
        logic [PLANE_W-1:0] act_hi;
        logic [PLANE_W-1:0] wgt_lo;
        logic [PLANE_W-1:0] wgt_hi;
        logic [CNT_W-1:0]   wnz;
        logic               last;
    } word_t;

    typedef struct {
        logic signed [RESULT_W-1:0] dot;
        logic                       too_long;
    } dot_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [PLANE_W-1:0]   i_act_plane_lo = '0;
    logic [PLANE_W-1:0]   i_act_plane_hi = '0;
    logic [PLANE_W-1:0]   i_wgt_plane_lo = '0;
    logic [PLANE_W-1:0]   i_wgt_plane_hi = '0;
    logic [CNT_W-1:0]     i_weight_nonzero_count = '0;
    logic                 i_last = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [RESULT_W-1:0] o_dot_result;
    logic                 o_too_long;

    // Predictor copy of configuration and run state
    logic [MODE_W-1:0] cfg_mode = '0;
    logic [CFG_W-1:0]  cfg_blen = '0;
    logic [CNT_W-1:0]  acc_one = '0;
    logic [CNT_W-1:0]  acc_two = '0;
    logic [CNT_W-1:0]  acc_three = '0;
    logic [CNT_W-1:0]  acc_four = '0;
    int                run_words = 0;
    logic              run_over = 1'b0;

    word_t pending_words[$];
    dot_t  expected_dots[$];
    word_t offered;

    int   mismatches = 0;
    int   cycle_count = 0;
    int   src_gap_max = 0;
    int   snk_gap_max = 0;
    int   src_wait = 0;
    int   snk_wait = 0;
    logic in_took = 1'b0;
    logic out_took = 1'b0;
    logic hold_arm = 1'b0;
    logic hold_on = 1'b0;
    int   hold_count = 0;

    ternary_binary_popcount_dot_product_core uut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_wr_en            (i_cfg_wr_en),
        .i_cfg_idx              (i_cfg_idx),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_act_plane_lo         (i_act_plane_lo),
        .i_act_plane_hi         (i_act_plane_hi),
        .i_wgt_plane_lo         (i_wgt_plane_lo),
        .i_wgt_plane_hi         (i_wgt_plane_hi),
        .i_weight_nonzero_count (i_weight_nonzero_count),
        .i_last                 (i_last),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_dot_result           (o_dot_result),
        .o_too_long             (o_too_long)
    );

    always #5 i_clk = ~i_clk;

    // Add a popcount to a run counter, saturating at the counter maximum
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] acc,
                                                 input int unsigned inc);
        int unsigned total;
        total = acc + inc;
        return (total > CNT_MAX) ? CNT_MAX : CNT_W'(total);
    endfunction

    // Advance the run counters by one accepted word and, on a last word, queue the run's dot product
    function automatic void accept_word(input word_t w);
        logic [PLANE_W-1:0] x;
        logic [PLANE_W-1:0] nz;
        longint sum;
        dot_t   res;
        if (run_words >= RUN_LIMIT) begin
            run_over = 1'b1;
        end else begin
            x = w.act_lo ^ w.wgt_lo;
            case (cfg_mode)
                MODE_TNN: begin
                    nz = w.act_hi & w.wgt_hi;
                    acc_one = sat_inc(acc_one, $countones(nz));
                    acc_two = sat_inc(acc_two, $countones(x & nz));
                end
                MODE_TBN: begin
                    acc_one = sat_inc(acc_one, $countones(w.act_hi));
                    acc_two = sat_inc(acc_two, $countones(x & w.act_hi));
                end
                MODE_BTN: begin
                    acc_two = sat_inc(acc_two, $countones(x & w.wgt_hi));
                end
                MODE_BNN: begin
                    acc_one = sat_inc(acc_one, $countones(x));
                end
                MODE_TWOBIT: begin
                    acc_one   = sat_inc(acc_one, $countones(w.act_lo & w.wgt_lo));
                    acc_two   = sat_inc(acc_two, $countones(w.act_hi & w.wgt_lo));
                    acc_three = sat_inc(acc_three, $countones(w.act_lo & w.wgt_hi));
                    acc_four  = sat_inc(acc_four, $countones(w.act_hi & w.wgt_hi));
                end
                MODE_RTN: begin
                    nz = w.act_lo & w.wgt_lo & RTN_EVEN_MASK;
                    acc_one = sat_inc(acc_one, $countones(nz));
                    acc_two = sat_inc(acc_two, $countones((x >> 1) & nz));
                end
                default: ;
            endcase
            run_words++;
        end

        if (w.last) begin
            case (cfg_mode)
                MODE_TNN, MODE_TBN, MODE_RTN:
                    sum = longint'(acc_one) - 2 * longint'(acc_two);
                MODE_BTN:
                    sum = longint'(w.wnz) - 2 * longint'(acc_two);
                MODE_BNN:
                    sum = longint'(cfg_blen) - 2 * longint'(acc_one);
                MODE_TWOBIT:
                    sum = 4 * longint'(acc_one)
                        + 2 * (longint'(acc_two) + longint'(acc_three))
                        + longint'(acc_four);
                default:
                    sum = 0;
            endcase
            if (sum > RES_MAX) sum = RES_MAX;
            if (sum < RES_MIN) sum = RES_MIN;
            res.dot = sum[RESULT_W-1:0];
            res.too_long = run_over;
            expected_dots.push_back(res);
            acc_one = '0;
            acc_two = '0;
            acc_three = '0;
            acc_four = '0;
            run_words = 0;
            run_over = 1'b0;
        end
    endfunction

    // Random plane word, biased toward empty, full, sparse and dense patterns
    function automatic logic [PLANE_W-1:0] rand_plane();
        logic [PLANE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = v & {$urandom, $urandom};
            3: v = v | {$urandom, $urandom};
            default: ;
        endcase
        return v;
    endfunction

    task automatic queue_word(input logic [PLANE_W-1:0] a_lo, input logic [PLANE_W-1:0] a_hi,
                              input logic [PLANE_W-1:0] w_lo, input logic [PLANE_W-1:0] w_hi,
                              input logic [CNT_W-1:0] wnz, input logic last);
        word_t w;
        w.act_lo = a_lo;
        w.act_hi = a_hi;
        w.wgt_lo = w_lo;
        w.wgt_hi = w_hi;
        w.wnz = wnz;
        w.last = last;
        pending_words.push_back(w);
    endtask

    task automatic queue_random_word(input logic last);
        logic [CNT_W-1:0] wnz;
        case ($urandom_range(0, 5))
            0: wnz = '0;
            1: wnz = WNZ_MID;
            2: wnz = '1;
            default: wnz = CNT_W'($urandom_range(0, 131071));
        endcase
        queue_word(rand_plane(), rand_plane(), rand_plane(), rand_plane(), wnz, last);
    endtask

    // Write one configuration register while the core is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        if (idx == REG_MODE)
            cfg_mode = data[MODE_W-1:0];
        else
            cfg_blen = data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Wait until all words are taken and all results checked, then drain
    task automatic settle();
        while (pending_words.size() != 0 || i_in_valid || expected_dots.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // Input driver: hold a stalled transaction, otherwise idle or offer the next word
    always @(negedge i_clk) begin
        word_t w;
        if (i_rst_n && !(i_in_valid && !in_took)) begin
            if (src_wait != 0) begin
                src_wait--;
                i_in_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                offered <= w;
                i_act_plane_lo <= w.act_lo;
                i_act_plane_hi <= w.act_hi;
                i_wgt_plane_lo <= w.wgt_lo;
                i_wgt_plane_hi <= w.wgt_hi;
                i_weight_nonzero_count <= w.wnz;
                i_last <= w.last;
                i_in_valid <= 1'b1;
                src_wait = $urandom_range(0, src_gap_max);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long output hold-off, counted on its own
    always @(negedge i_clk) begin
        if (hold_arm && hold_count < HOLD_CYCLES) begin
            hold_on <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            hold_on <= 1'b0;
        end
    end

    // Output stall driver: draw a new wait after each taken result
    always @(negedge i_clk) begin
        if (out_took)
            snk_wait = $urandom_range(0, snk_gap_max);
        i_out_stall <= hold_on || (snk_wait != 0);
        if (o_out_valid && snk_wait != 0 && !hold_on)
            snk_wait--;
    end

    // Monitor: predict on accepted words, check accepted results
    always @(posedge i_clk) begin
        dot_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: no finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            in_took = 1'b0;
            out_took = 1'b0;
            if (i_rst_n) begin
                if (i_in_valid && !o_in_stall) begin
                    in_took = 1'b1;
                    accept_word(offered);
                end
                if (o_out_valid && !i_out_stall) begin
                    out_took = 1'b1;
                    if (expected_dots.size() == 0) begin
                        $display("%0t: expected no result, actual dot_result %0d too_long %0b",
                                 $time, o_dot_result, o_too_long);
                        mismatches++;
                    end else begin
                        want = expected_dots.pop_front();
                        if (o_dot_result !== want.dot) begin
                            $display("%0t: dot_result expected %0d actual %0d",
                                     $time, want.dot, o_dot_result);
                            mismatches++;
                        end
                        if (o_too_long !== want.too_long) begin
                            $display("%0t: too_long expected %0b actual %0b",
                                     $time, want.too_long, o_too_long);
                            mismatches++;
                        end
                    end
                end
            end
        end
    end

    // Stimulus
    initial begin
        int random_words;
        int runs;
        int len;
        logic [CFG_W-1:0] blen;
        logic [MODE_W-1:0] pick;
        logic close_run;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Ternary-ternary from reset: all agree, all disagree, all zero
        src_gap_max = 2;
        snk_gap_max = 2;
        queue_word('1, '1, '1, '1, '0, 1'b1);
        queue_word('1, '1, '0, '1, '1, 1'b1);
        queue_word('0, '0, '0, '0, '1, 1'b1);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_TBN));
        queue_word('1, '1, '0, '0, '0, 1'b1);
        queue_word('0, '1, '0, '0, '0, 1'b1);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_BTN));
        queue_word('1, '0, '0, '1, WNZ_MID, 1'b1);
        queue_word('0, '0, '0, '0, '0, 1'b1);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_BNN));
        write_reg(REG_BINARY_LENGTH, CFG_W'(WNZ_MID));
        queue_word('1, '0, '0, '0, '0, 1'b1);
        settle();
        write_reg(REG_BINARY_LENGTH, '0);
        queue_word('1, '0, '0, '0, '0, 1'b1);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_TWOBIT));
        queue_word('1, '1, '1, '1, '0, 1'b1);
        queue_word('0, '0, '0, '0, '0, 1'b1);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_RTN));
        queue_word('1, '0, '1, '0, '0, 1'b1);
        queue_word('1, '0, RTN_EVEN_MASK, '0, '0, 1'b1);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_SPARE_6));
        queue_word('1, '1, '1, '1, '1, 1'b1);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_SPARE_7));
        queue_word('1, '1, '0, '1, '1, 1'b1);
        settle();

        // Switch mode between two words of one run
        write_reg(REG_MODE, CFG_W'(MODE_TNN));
        queue_word('1, '1, '1, '1, '0, 1'b0);
        settle();
        write_reg(REG_MODE, CFG_W'(MODE_BNN));
        write_reg(REG_BINARY_LENGTH, 17'd64);
        queue_word('1, '0, '0, '0, '0, 1'b1);
        settle();

        // Run one word past the limit: every word up to the limit counts, the extra one not
        src_gap_max = 0;
        snk_gap_max = 0;
        write_reg(REG_MODE, CFG_W'(MODE_BNN));
        write_reg(REG_BINARY_LENGTH, '0);
        for (int i = 1; i <= RUN_LIMIT + 1; i++)
            queue_word('1, rand_plane(), '0, rand_plane(), '0, i == RUN_LIMIT + 1);
        settle();

        // Random phases; the first one holds off the output to back up the input
        random_words = 0;
        while (random_words < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) < 8)
                pick = MODE_W'($urandom_range(0, 5));
            else
                pick = MODE_W'($urandom_range(6, 7));
            write_reg(REG_MODE, CFG_W'(pick));
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0: blen = '0;
                    1: blen = CFG_W'(WNZ_MID);
                    2: blen = '1;
                    default: blen = CFG_W'($urandom_range(0, 131071));
                endcase
                write_reg(REG_BINARY_LENGTH, blen);
            end
            case ($urandom_range(0, 2))
                0: src_gap_max = 0;
                1: src_gap_max = 3;
                default: src_gap_max = 18;
            endcase
            case ($urandom_range(0, 2))
                0: snk_gap_max = 0;
                1: snk_gap_max = 3;
                default: snk_gap_max = 18;
            endcase
            runs = $urandom_range(6, 24);
            if (!hold_arm) begin
                src_gap_max = 0;
                runs = 40;
                hold_arm = 1'b1;
            end
            for (int r = 0; r < runs; r++) begin
                if (hold_count == 0 && hold_arm)
                    len = $urandom_range(1, 2);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(7, 60);
                else
                    len = $urandom_range(1, 4);
                // Leave the last run open now and then so the next mode applies mid-run
                close_run = (r != runs - 1) || ($urandom_range(0, 7) != 0);
                for (int i = 1; i <= len; i++)
                    queue_random_word(close_run && i == len);
                random_words += len;
            end
            settle();
        end

        // Close any open run
        queue_random_word(1'b1);
        settle();

        if (mismatches == 0 && expected_dots.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- ternary_binary_popcount_dot_product_core.f -----
rtl/core/tbpd_pkg.sv
rtl/core/tbpd_lane.sv
rtl/core/tbpd_merge.sv
rtl/core/ternary_binary_popcount_dot_product_core.sv
test/ternary_binary_popcount_dot_product_core_tb.sv
